FILE: src/arp_cache_lru_unit_defines.svh
// Assertion macros for the neighbour cache checker.
// Used by acl_checker only; no other dependencies.
`ifndef ARP_CACHE_LRU_UNIT_DEFINES_SVH
`define ARP_CACHE_LRU_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define ACL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define ACL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/acl_pkg.sv
// Shared types and constants for the neighbour cache (ARP cache, LRU replacement).
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package acl_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int IP_W    = 32;
	localparam int MAC_W   = 48;
	localparam int STAMP_W = 32;
	localparam int SLOT_W  = 4;
	localparam int CFG_W   = 32;

	// configuration register indexes
	localparam logic CFG_OWN_IP = 1'b0;
	localparam logic CFG_MASK   = 1'b1;

	// command codes
	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_LEARN  = 1'b1;

	// search record handed from cell to cell
	typedef struct packed {
		logic               vld;
		logic [IP_W-1:0]    ip;
		logic               hit;
		logic [IDX_W-1:0]   hit_idx;
		logic [MAC_W-1:0]   hit_mac;
		logic               emp;
		logic [IDX_W-1:0]   emp_idx;
		logic [IDX_W-1:0]   old_idx;
		logic [STAMP_W-1:0] old_stamp;
	} srch_t;

	// entry write broadcast to all cells
	typedef struct packed {
		logic               en;
		logic [IDX_W-1:0]   idx;
		logic [IP_W-1:0]    ip;
		logic [MAC_W-1:0]   mac;
		logic [STAMP_W-1:0] stamp;
	} wr_t;

endpackage

FILE: src/acl_cell.sv
// One cache entry plus one stage of the search chain.
// Depends on acl_pkg for the search record and write types.
`timescale 1ns / 1ps

module acl_cell import acl_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] cell_idx,
	input  srch_t            srch_in,
	input  wr_t              wr,
	output srch_t            srch_out
);

	logic [IP_W-1:0]    ip_q;
	logic [MAC_W-1:0]   mac_q;
	logic [STAMP_W-1:0] stamp_q;
	logic               vld_q;
	srch_t              nxt;
	srch_t              rec_q;
	logic               used;
	logic               match;

	// entry storage; an all-zero MAC marks the entry empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_q <= '0;
		end else if (wr.en && wr.idx == cell_idx) begin
			mac_q <= wr.mac;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && wr.idx == cell_idx) begin
			ip_q    <= wr.ip;
			stamp_q <= wr.stamp;
		end
	end

	// fold this entry into the passing record; earlier cells take priority
	assign used  = (mac_q != '0);
	assign match = used && (ip_q == srch_in.ip);

	always_comb begin
		nxt = srch_in;
		if (!srch_in.hit && match) begin
			nxt.hit     = 1'b1;
			nxt.hit_idx = cell_idx;
			nxt.hit_mac = mac_q;
		end
		if (!srch_in.emp && !used) begin
			nxt.emp     = 1'b1;
			nxt.emp_idx = cell_idx;
		end
		if (stamp_q < srch_in.old_stamp) begin
			nxt.old_idx   = cell_idx;
			nxt.old_stamp = stamp_q;
		end
	end

	// advance the record to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= srch_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		rec_q <= nxt;
	end

	always_comb begin
		srch_out     = rec_q;
		srch_out.vld = vld_q;
	end

endmodule

FILE: src/arp_cache_lru_unit.sv
// Top level of the neighbour cache: control, registers and the chain of entry cells.
// Depends on acl_pkg and acl_cell.
`timescale 1ns / 1ps
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  input    | in_valid / in_stall  | command, ip_addr, mac_addr
//  output   | out_valid / out_stall| found_mac, hit, is_bcast, slot_used
//  config   | cfg_we               | cfg_index, cfg_data
//
//  An item must be finished before the next transfer is possible: the search record
//  walks the chain one cell per cycle. The result sits in an output register; a
//  stalled result holds the block in its finish state, and the entry update waits
//  with it.
//  Reset empties every entry and clears the use counter and both registers.

module arp_cache_lru_unit import acl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              command,
	input  logic [IP_W-1:0]   ip_addr,
	input  logic [MAC_W-1:0]  mac_addr,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [MAC_W-1:0]  found_mac,
	output logic              hit,
	output logic              is_bcast,
	output logic [SLOT_W-1:0] slot_used,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;
	localparam logic [1:0] ST_FINISH = 2'd2;

	logic [1:0]         state_q;
	logic               launch_q;
	logic               cmd_q;
	logic [IP_W-1:0]    ip_q;
	logic [MAC_W-1:0]   mac_q;
	logic [IP_W-1:0]    own_ip_q;
	logic [IP_W-1:0]    mask_q;
	logic [STAMP_W-1:0] counter_q;
	srch_t              tail_q;
	logic               out_valid_q;
	logic [MAC_W-1:0]   found_q;
	logic               hit_q;
	logic               bcast_q;
	logic [SLOT_W-1:0]  slot_q;

	srch_t              chain [ENTRIES+1];
	wr_t                wr;
	logic               in_xfer;
	logic               out_free;
	logic               finish;
	logic               bcast;
	logic               learn_ok;
	logic [IDX_W-1:0]   target;
	logic [STAMP_W-1:0] stamp_next;
	logic [MAC_W-1:0]   res_found;
	logic               res_hit;
	logic               res_bcast;
	logic [IDX_W-1:0]   res_idx;
	logic [SLOT_W+IDX_W-1:0] slot_ext;

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign finish   = (state_q == ST_FINISH) && out_free;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q <= '0;
			mask_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_OWN_IP: own_ip_q <= cfg_data[IP_W-1:0];
				CFG_MASK:   mask_q   <= cfg_data[IP_W-1:0];
				default:    ;
			endcase
		end
	end

	// control sequence: idle, walk the chain, finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			launch_q <= 1'b0;
		end else begin
			launch_q <= in_xfer;
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (chain[ENTRIES].vld) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// hold the accepted item and the finished search record
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_q <= command;
			ip_q  <= ip_addr;
			mac_q <= mac_addr;
		end
		if (chain[ENTRIES].vld) begin
			tail_q <= chain[ENTRIES];
		end
	end

	// launch a fresh record into the first cell
	always_comb begin
		chain[0]           = '0;
		chain[0].vld       = launch_q;
		chain[0].ip        = ip_q;
		chain[0].old_stamp = '1;
	end

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		acl_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (IDX_W'(g)),
			.srch_in  (chain[g]),
			.wr       (wr),
			.srch_out (chain[g+1])
		);
	end

	// classify, pick the victim and form the result
	assign bcast = (ip_q == '1) ||
		((mask_q != '0) && (ip_q == (own_ip_q | ~mask_q)));
	assign learn_ok = (ip_q != '0) && (mac_q != '0) && (mac_q != '1);
	assign stamp_next = counter_q + STAMP_W'(1);

	always_comb begin
		if (tail_q.hit) begin
			target = tail_q.hit_idx;
		end else if (tail_q.emp) begin
			target = tail_q.emp_idx;
		end else begin
			target = tail_q.old_idx;
		end
	end

	always_comb begin
		res_found = '0;
		res_hit   = 1'b0;
		res_bcast = 1'b0;
		res_idx   = '0;
		case (cmd_q)
			CMD_LOOKUP: begin
				if (bcast) begin
					res_found = '1;
					res_hit   = 1'b1;
					res_bcast = 1'b1;
				end else if (tail_q.hit) begin
					res_found = tail_q.hit_mac;
					res_hit   = 1'b1;
					res_idx   = tail_q.hit_idx;
				end
			end
			CMD_LEARN: begin
				if (learn_ok) begin
					res_hit = 1'b1;
					res_idx = target;
				end
			end
			default: ;
		endcase
	end

	assign slot_ext = {{SLOT_W{1'b0}}, res_idx};

	always_comb begin
		wr.en    = finish && (cmd_q == CMD_LEARN) && learn_ok;
		wr.idx   = target;
		wr.ip    = ip_q;
		wr.mac   = mac_q;
		wr.stamp = stamp_next;
	end

	// advance the use counter on every accepted learn
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
		end else if (wr.en) begin
			counter_q <= stamp_next;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			found_q <= res_found;
			hit_q   <= res_hit;
			bcast_q <= res_bcast;
			slot_q  <= slot_ext[SLOT_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign found_mac = found_q;
	assign hit       = hit_q;
	assign is_bcast  = bcast_q;
	assign slot_used = slot_q;

endmodule

FILE: src/acl_checker.sv
// Port-level checks for the neighbour cache, bound to the top level.
// Depends on acl_pkg and arp_cache_lru_unit_defines.svh.
`timescale 1ns / 1ps
`include "arp_cache_lru_unit_defines.svh"

module acl_checker import acl_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic [MAC_W-1:0]  found_mac,
	input logic              hit,
	input logic              is_bcast,
	input logic [SLOT_W-1:0] slot_used
);

	// a stalled result holds
	`ACL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(found_mac), "stalled result changed")

	// one item at a time: busy straight after a transfer
	`ACL_ASSERT_NEXT(a_busy, in_valid && !in_stall, in_stall, "input taken while busy")

	// broadcast answers carry the all-ones MAC and no slot
	`ACL_ASSERT_NOW(a_bcast, out_valid && is_bcast, hit && (slot_used == '0) && (found_mac == '1), "bad broadcast result")

	// a miss or rejected learn reports nothing
	`ACL_ASSERT_NOW(a_miss, out_valid && !hit, (found_mac == '0) && (slot_used == '0) && !is_bcast, "miss result not clear")

endmodule

bind arp_cache_lru_unit acl_checker u_acl_checker (.*);

FILE: tb/sv/tb_arp_cache_lru_unit.sv
// Self-checking bench for arp_cache_lru_unit: directed table, then random lookups and learns
// under several netmask settings, each checked against an in-bench model of the cache.
// Depends on acl_pkg and the arp_cache_lru_unit RTL only.
`timescale 1ns / 1ps

module tb_arp_cache_lru_unit;
	import acl_pkg::*;

	localparam int ITEM_CYCLES = ENTRIES + 3;
	localparam int WATCHDOG    = 2000;
	localparam int POOL_SIZE   = 24;
	localparam int SEG_ITEMS   = 192;

	typedef struct packed {
		logic [MAC_W-1:0]  mac;
		logic              hit;
		logic              bcast;
		logic [SLOT_W-1:0] slot;
	} answer_t;

	typedef struct {
		logic             cmd;
		logic [IP_W-1:0]  ip;
		logic [MAC_W-1:0] mac;
		bit               known;
		answer_t          ans;
	} dir_row_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic              command;
	logic [IP_W-1:0]   ip_addr;
	logic [MAC_W-1:0]  mac_addr;
	logic              out_valid;
	logic              out_stall;
	logic [MAC_W-1:0]  found_mac;
	logic              hit;
	logic              is_bcast;
	logic [SLOT_W-1:0] slot_used;
	logic              cfg_we;
	logic              cfg_index;
	logic [CFG_W-1:0]  cfg_data;

	// model of the cache: table, use counter and both registers
	logic [IP_W-1:0]    nc_ip    [ENTRIES];
	logic [MAC_W-1:0]   nc_mac   [ENTRIES];
	logic [31:0]        nc_stamp [ENTRIES];
	logic [31:0]        learn_seq;
	logic [IP_W-1:0]    reg_own;
	logic [IP_W-1:0]    reg_mask;

	answer_t  pending_answers [$];
	dir_row_t dir_rows [$];
	int       mismatch_count;
	int       send_gap_pct;
	int       recv_stall_pct;
	bit       send_calm;
	bit       recv_calm;
	int       quiet_cycles;

	arp_cache_lru_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.ip_addr   (ip_addr),
		.mac_addr  (mac_addr),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.found_mac (found_mac),
		.hit       (hit),
		.is_bcast  (is_bcast),
		.slot_used (slot_used),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// broadcast test as the block applies it to a lookup address
	function automatic bit is_broadcast(input logic [IP_W-1:0] addr);
		return (addr == '1) || (reg_mask != '0 && addr == (reg_own | ~reg_mask));
	endfunction

	// answer one lookup or learn and apply any table update
	function automatic answer_t resolve_neighbour(input logic cmd, input logic [IP_W-1:0] ip,
			input logic [MAC_W-1:0] mac);
		answer_t ans;
		bit      matched;
		bit      have_empty;
		int      target;
		int      empty_idx;
		int      oldest;
		ans = '0;
		if (cmd == CMD_LOOKUP) begin
			if (is_broadcast(ip)) begin
				ans.mac   = '1;
				ans.hit   = 1'b1;
				ans.bcast = 1'b1;
			end else begin
				for (int k = 0; k < ENTRIES; k++) begin
					if (!ans.hit && nc_mac[k] != '0 && nc_ip[k] == ip) begin
						ans.mac  = nc_mac[k];
						ans.hit  = 1'b1;
						ans.slot = SLOT_W'(k);
					end
				end
			end
		end else if (ip != '0 && mac != '0 && mac != '1) begin
			matched    = 1'b0;
			have_empty = 1'b0;
			target     = 0;
			empty_idx  = 0;
			oldest     = 0;
			for (int k = 0; k < ENTRIES; k++) begin
				if (!matched && nc_mac[k] != '0 && nc_ip[k] == ip) begin
					matched = 1'b1;
					target  = k;
				end
				if (!have_empty && nc_mac[k] == '0) begin
					have_empty = 1'b1;
					empty_idx  = k;
				end
				if (nc_stamp[k] < nc_stamp[oldest])
					oldest = k;
			end
			if (!matched)
				target = have_empty ? empty_idx : oldest;
			learn_seq        = learn_seq + 32'd1;
			nc_ip[target]    = ip;
			nc_mac[target]   = mac;
			nc_stamp[target] = learn_seq;
			ans.hit          = 1'b1;
			ans.slot         = SLOT_W'(target);
		end
		return ans;
	endfunction

	function automatic dir_row_t row(input logic cmd, input logic [IP_W-1:0] ip,
			input logic [MAC_W-1:0] mac, input bit known, input logic [MAC_W-1:0] fm,
			input logic h, input logic b, input logic [SLOT_W-1:0] s);
		dir_row_t r;
		r.cmd       = cmd;
		r.ip        = ip;
		r.mac       = mac;
		r.known     = known;
		r.ans.mac   = fm;
		r.ans.hit   = h;
		r.ans.bcast = b;
		r.ans.slot  = s;
		return r;
	endfunction

	// offer one item, hold it until the transfer, then log its expected answer
	task automatic send_item(input logic cmd, input logic [IP_W-1:0] ip,
			input logic [MAC_W-1:0] mac, input bit known, input answer_t fixed_ans);
		answer_t predicted;
		if ($urandom_range(0, 19) == 0)
			send_calm = !send_calm;
		if (!send_calm && $urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 2 * ITEM_CYCLES)) @(negedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		ip_addr  <= ip;
		mac_addr <= mac;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predicted = resolve_neighbour(cmd, ip, mac);
		pending_answers.push_back(known ? fixed_ans : predicted);
		@(negedge clk);
	endtask

	// stop offering, wait for every answer, then let any table update settle
	task automatic quiesce();
		in_valid <= 1'b0;
		while (pending_answers.size() != 0) @(negedge clk);
		repeat (ITEM_CYCLES) @(negedge clk);
	endtask

	task automatic program_regs(input logic [CFG_W-1:0] own, input logic [CFG_W-1:0] mask);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_OWN_IP;
		cfg_data  <= own;
		@(negedge clk);
		cfg_index <= CFG_MASK;
		cfg_data  <= mask;
		@(negedge clk);
		cfg_we   <= 1'b0;
		reg_own  = own;
		reg_mask = mask;
	endtask

	// receiver: stall at random, with calm stretches
	initial begin
		out_stall <= 1'b0;
		recv_calm = 1'b0;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 39) == 0)
				recv_calm = !recv_calm;
			out_stall <= !recv_calm && ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// check each result transfer against the oldest expectation
	always @(posedge clk) begin
		answer_t exp_ans;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_answers.size() == 0) begin
				$error("unexpected result: found_mac %h hit %b is_bcast %b slot_used %0d",
					found_mac, hit, is_bcast, slot_used);
				mismatch_count++;
			end else begin
				exp_ans = pending_answers.pop_front();
				if (found_mac !== exp_ans.mac) begin
					$error("found_mac: expected %h, got %h", exp_ans.mac, found_mac);
					mismatch_count++;
				end
				if (hit !== exp_ans.hit) begin
					$error("hit: expected %b, got %b", exp_ans.hit, hit);
					mismatch_count++;
				end
				if (is_bcast !== exp_ans.bcast) begin
					$error("is_bcast: expected %b, got %b", exp_ans.bcast, is_bcast);
					mismatch_count++;
				end
				if (slot_used !== exp_ans.slot) begin
					$error("slot_used: expected %0d, got %0d", exp_ans.slot, slot_used);
					mismatch_count++;
				end
			end
		end
	end

	// end the run when no transfer happens for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG) begin
			$display("arp_cache_lru_unit verification failed");
			$finish;
		end
	end

	initial begin
		logic [IP_W-1:0]  ip_pool [POOL_SIZE];
		logic [CFG_W-1:0] seg_own;
		logic [CFG_W-1:0] seg_mask;
		logic             r_cmd;
		logic [IP_W-1:0]  r_ip;
		logic [MAC_W-1:0] r_mac;
		int               pick;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		command   <= CMD_LOOKUP;
		ip_addr   <= '0;
		mac_addr  <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= CFG_OWN_IP;
		cfg_data  <= '0;
		quiet_cycles   = 0;
		mismatch_count = 0;
		send_calm      = 1'b0;
		send_gap_pct   = 24;
		recv_stall_pct = 72;
		learn_seq      = '0;
		reg_own        = '0;
		reg_mask       = '0;
		for (int k = 0; k < ENTRIES; k++) begin
			nc_ip[k]    = '0;
			nc_mac[k]   = '0;
			nc_stamp[k] = '0;
		end

		// directed table, run with own address C0A80105 on a /24
		dir_rows.push_back(row(CMD_LOOKUP, 32'h0000_0000, 48'h0, 1, 48'h0, 0, 0, 0));
		dir_rows.push_back(row(CMD_LOOKUP, 32'hFFFF_FFFF, '1, 1, '1, 1, 1, 0));
		dir_rows.push_back(row(CMD_LOOKUP, 32'hC0A8_01FF, 48'h0, 1, '1, 1, 1, 0));
		dir_rows.push_back(row(CMD_LEARN, 32'h0000_0000, 48'h1, 1, 48'h0, 0, 0, 0));
		dir_rows.push_back(row(CMD_LEARN, 32'h0A00_0001, 48'h0, 1, 48'h0, 0, 0, 0));
		dir_rows.push_back(row(CMD_LEARN, 32'h0A00_0001, '1, 1, 48'h0, 0, 0, 0));
		dir_rows.push_back(row(CMD_LOOKUP, 32'h0A00_0001, 48'h0, 1, 48'h0, 0, 0, 0));
		dir_rows.push_back(row(CMD_LEARN, 32'h0A00_0001, 48'h1, 1, 48'h0, 1, 0, 0));
		dir_rows.push_back(row(CMD_LOOKUP, 32'h0A00_0001, '1, 1, 48'h1, 1, 0, 0));
		dir_rows.push_back(row(CMD_LEARN, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFE, 1, 48'h0, 1, 0, 1));
		dir_rows.push_back(row(CMD_LOOKUP, 32'hFFFF_FFFF, 48'h0, 1, '1, 1, 1, 0));
		dir_rows.push_back(row(CMD_LEARN, 32'hC0A8_01FF, 48'h8000_0000_0000, 1, 48'h0, 1, 0, 2));
		dir_rows.push_back(row(CMD_LOOKUP, 32'hC0A8_01FF, 48'h0, 1, '1, 1, 1, 0));
		dir_rows.push_back(row(CMD_LEARN, 32'h0A00_0001, 48'hFEDC_BA98_7654, 1, 48'h0, 1, 0, 0));
		dir_rows.push_back(row(CMD_LOOKUP, 32'h0A00_0001, 48'h0, 1, 48'hFEDC_BA98_7654, 1, 0, 0));
		dir_rows.push_back(row(CMD_LEARN, 32'hC0A8_0105, 48'h0123_4567_89AB, 1, 48'h0, 1, 0, 3));
		dir_rows.push_back(row(CMD_LOOKUP, 32'hC0A8_0105, 48'h0, 1, 48'h0123_4567_89AB, 1, 0, 3));
		dir_rows.push_back(row(CMD_LOOKUP, 32'h7FFF_FFFF, 48'h0, 1, 48'h0, 0, 0, 0));
		dir_rows.push_back(row(CMD_LEARN, 32'h7FFF_FFFF, 48'h5555_5555_5555, 0, 48'h0, 0, 0, 0));
		dir_rows.push_back(row(CMD_LOOKUP, 32'h7FFF_FFFF, 48'h0, 0, 48'h0, 0, 0, 0));
		dir_rows.push_back(row(CMD_LEARN, 32'h8000_0000, 48'hAAAA_AAAA_AAAA, 0, 48'h0, 0, 0, 0));
		dir_rows.push_back(row(CMD_LOOKUP, 32'hFFFF_FFFE, 48'h0, 0, 48'h0, 0, 0, 0));
		dir_rows.push_back(row(CMD_LOOKUP, 32'h8000_0000, 48'h0, 0, 48'h0, 0, 0, 0));

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		program_regs(32'hC0A8_0105, 32'hFFFF_FF00);
		foreach (dir_rows[i])
			send_item(dir_rows[i].cmd, dir_rows[i].ip, dir_rows[i].mac, dir_rows[i].known,
				dir_rows[i].ans);

		// random segments, one register setting each; drain fully before every change
		for (int seg = 0; seg < 6; seg++) begin
			quiesce();
			case (seg)
				0: begin
					seg_own  = '0;
					seg_mask = '0;
				end
				1: begin
					seg_own  = '1;
					seg_mask = '1;
				end
				2: begin
					seg_own  = $urandom();
					seg_mask = 32'hFFFF_FF00;
				end
				3: begin
					seg_own  = $urandom();
					seg_mask = 32'hFFFF_FFFF << $urandom_range(1, 24);
				end
				4: begin
					seg_own  = $urandom();
					seg_mask = $urandom();
				end
				default: begin
					seg_own  = '0;
					seg_mask = '1;
				end
			endcase
			program_regs(seg_own, seg_mask);
			send_gap_pct   = (seg < 2) ? 24 : (seg < 4) ? 72 : 0;
			recv_stall_pct = (seg < 2) ? 72 : (seg < 4) ? 24 : 0;
			for (int k = 0; k < POOL_SIZE; k++)
				ip_pool[k] = $urandom();

			// more addresses than entries, so learns keep evicting
			repeat (SEG_ITEMS) begin
				r_cmd = ($urandom_range(0, 99) < 45) ? CMD_LEARN : CMD_LOOKUP;
				pick  = $urandom_range(0, 99);
				if (pick < 70)
					r_ip = ip_pool[$urandom_range(0, POOL_SIZE - 1)];
				else if (pick < 78)
					r_ip = seg_own | ~seg_mask;
				else if (pick < 83)
					r_ip = '1;
				else if (pick < 88)
					r_ip = '0;
				else if (pick < 92)
					r_ip = seg_own;
				else
					r_ip = $urandom();
				pick = $urandom_range(0, 99);
				if (pick < 5)
					r_mac = '0;
				else if (pick < 10)
					r_mac = '1;
				else
					r_mac = {16'($urandom()), 32'($urandom())};
				send_item(r_cmd, r_ip, r_mac, 1'b0, '0);
			end
		end

		quiesce();
		if (mismatch_count == 0) begin
			$display("arp_cache_lru_unit verification clean");
		end else begin
			$display("arp_cache_lru_unit verification failed");
		end
		$finish;
	end

endmodule

FILE: files.f
+incdir+src
src/acl_pkg.sv
src/acl_cell.sv
src/arp_cache_lru_unit.sv
src/acl_checker.sv
tb/sv/tb_arp_cache_lru_unit.sv
